[design/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, register map, datapath operations and status for the
// midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int COORD_BITS = 11;
	localparam int CTR_W      = 11;
	localparam int RAD_W      = 10;
	localparam int SQ_W       = 2 * RAD_W;
	localparam int SLOPE_W    = 32;
	localparam int DEC_W      = 44;
	localparam int OUT_W      = 13;
	localparam int MUL_W      = (2 * COORD_BITS > SQ_W) ? 2 * COORD_BITS : SQ_W;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int SUM_W      = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 4;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS_X = 2'd2,
		REG_RADIUS_Y = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CTR_W-1:0] center_x;
		logic [CTR_W-1:0] center_y;
		logic [RAD_W-1:0] radius_x;
		logic [RAD_W-1:0] radius_y;
	} mer_cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START_INIT,
		OP_START_DEC,
		OP_START_FIN,
		OP_IDLE_EMIT,
		OP_STEP,
		OP_SW_M1,
		OP_SW_M2,
		OP_SW_M3,
		OP_SW_M4,
		OP_SW_M5,
		OP_SW_FIN
	} dp_op_t;

	typedef struct packed {
		logic active;
		logic region_two;
		logic r1_go;
		logic out_free;
	} mer_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_INIT,
		S_DEC,
		S_FIN,
		S_SW2,
		S_SW3,
		S_SW4,
		S_SW5,
		S_SWFIN
	} mer_state_t;

endpackage

[design/mer_regs.sv]
// ----------------------------------------------------------------------------
// mer_regs
// APB register file holding the ellipse centre and radii.
// ----------------------------------------------------------------------------
module mer_regs
	import mer_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output mer_cfg_t          cfg
);

	mer_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER_X: cfg_q.center_x <= pwdata[CTR_W-1:0];
				REG_CENTER_Y: cfg_q.center_y <= pwdata[CTR_W-1:0];
				REG_RADIUS_X: cfg_q.radius_x <= pwdata[RAD_W-1:0];
				REG_RADIUS_Y: cfg_q.radius_y <= pwdata[RAD_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_X: prdata = DATA_W'(cfg_q.center_x);
			REG_CENTER_Y: prdata = DATA_W'(cfg_q.center_y);
			REG_RADIUS_X: prdata = DATA_W'(cfg_q.radius_x);
			REG_RADIUS_Y: prdata = DATA_W'(cfg_q.radius_y);
		endcase
	end

endmodule

[design/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: takes one item at a time and issues datapath operations for
// start, step, the empty result after a walk and the region-two changeover.
// ----------------------------------------------------------------------------
module mer_ctrl
	import mer_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      start_req,
	output logic      in_stall,
	input  mer_stat_t stat,
	output dp_op_t    op
);

	mer_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = start_req ? S_INIT : S_EXEC;
				end
			end
			S_INIT: begin
				op        = OP_START_INIT;
				state_nxt = S_DEC;
			end
			S_DEC: begin
				op        = OP_START_DEC;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					op        = OP_START_FIN;
					state_nxt = S_IDLE;
				end
			end
			S_EXEC: begin
				priority if (!stat.active) begin
					if (stat.out_free) begin
						op        = OP_IDLE_EMIT;
						state_nxt = S_IDLE;
					end
				end else if (stat.r1_go || stat.region_two) begin
					if (stat.out_free) begin
						op        = OP_STEP;
						state_nxt = S_IDLE;
					end
				end else begin
					op        = OP_SW_M1;
					state_nxt = S_SW2;
				end
			end
			S_SW2: begin
				op        = OP_SW_M2;
				state_nxt = S_SW3;
			end
			S_SW3: begin
				op        = OP_SW_M3;
				state_nxt = S_SW4;
			end
			S_SW4: begin
				op        = OP_SW_M4;
				state_nxt = S_SW5;
			end
			S_SW5: begin
				op        = OP_SW_M5;
				state_nxt = S_SWFIN;
			end
			S_SWFIN: begin
				op        = OP_SW_FIN;
				state_nxt = S_EXEC;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

[design/mer_dp.sv]
// ----------------------------------------------------------------------------
// mer_dp
// Walk state, shared multiplier, decision update and output register.
// ----------------------------------------------------------------------------
module mer_dp
	import mer_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mer_cfg_t                cfg,
	input  dp_op_t                  op,
	output mer_stat_t               stat,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] px_right,
	output logic signed [OUT_W-1:0] px_left,
	output logic signed [OUT_W-1:0] py_down,
	output logic signed [OUT_W-1:0] py_up,
	output logic                    point_valid,
	output logic                    done_res
);

	function automatic logic [DEC_W-1:0] sext(input logic [SLOPE_W-1:0] v);
		return {{(DEC_W-SLOPE_W){v[SLOPE_W-1]}}, v};
	endfunction

	logic [COORD_BITS-1:0] x_q, y_q, x_n, y_n;
	logic [SLOPE_W-1:0]    dx_q, dy_q, dx_n, dy_n, dx_inc, dy_dec;
	logic [DEC_W-1:0]      dec_q, dec_step, prod_q, a2e, b2e;
	logic [SQ_W-1:0]       a2_q, b2_q;
	logic [SQ_W:0]         two_a2, two_b2;
	logic                  r2_q, active_q, out_valid_q;
	logic [MUL_W-1:0]      mul_a, mul_b;
	logic [PROD_W-1:0]     mul_p;
	logic                  dec_neg, dec_pos, emit, r1_go;
	logic [SUM_W-1:0]      cx_w, cy_w, xw, yw, s_r, s_l, s_d, s_u;

	// squares of the radius registers, registered
	always_ff @(posedge clk) begin
		a2_q <= SQ_W'(cfg.radius_x) * SQ_W'(cfg.radius_x);
		b2_q <= SQ_W'(cfg.radius_y) * SQ_W'(cfg.radius_y);
	end

	assign two_a2 = {a2_q, 1'b0};
	assign two_b2 = {b2_q, 1'b0};
	assign a2e    = DEC_W'(a2_q);
	assign b2e    = DEC_W'(b2_q);

	assign dx_inc  = dx_q + SLOPE_W'(two_b2);
	assign dy_dec  = dy_q - SLOPE_W'(two_a2);
	assign dec_neg = dec_q[DEC_W-1];
	assign dec_pos = !dec_q[DEC_W-1] && (|dec_q);
	assign r1_go   = !r2_q && ($signed(dx_q) < $signed(dy_q));

	always_comb begin
		x_n      = x_q;
		y_n      = y_q;
		dx_n     = dx_q;
		dy_n     = dy_q;
		dec_step = dec_q;
		if (op == OP_STEP) begin
			if (r1_go) begin
				x_n  = x_q + 1'b1;
				dx_n = dx_inc;
				if (dec_neg) begin
					dec_step = dec_q + b2e + sext(dx_inc);
				end else begin
					y_n      = y_q - 1'b1;
					dy_n     = dy_dec;
					dec_step = dec_q + b2e + sext(dx_inc) - sext(dy_dec);
				end
			end else begin
				y_n  = y_q - 1'b1;
				dy_n = dy_dec;
				if (dec_pos) begin
					dec_step = dec_q + a2e - sext(dy_dec);
				end else begin
					x_n      = x_q + 1'b1;
					dx_n     = dx_inc;
					dec_step = dec_q + a2e - sext(dy_dec) + sext(dx_inc);
				end
			end
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_START_INIT: begin
				mul_a = MUL_W'(a2_q);
				mul_b = MUL_W'(cfg.radius_y);
			end
			OP_START_DEC: begin
				mul_a = MUL_W'(a2_q);
				mul_b = MUL_W'(y_q);
			end
			OP_SW_M1: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'({1'b0, x_q} + 1'b1);
			end
			OP_SW_M2: begin
				mul_a = MUL_W'(b2_q);
				mul_b = prod_q[MUL_W-1:0];
			end
			OP_SW_M3: begin
				mul_a = MUL_W'(y_q - 1'b1);
				mul_b = MUL_W'(y_q - 1'b1);
			end
			OP_SW_M4: begin
				mul_a = MUL_W'(a2_q);
				mul_b = prod_q[MUL_W-1:0];
			end
			OP_SW_M5: begin
				mul_a = MUL_W'(a2_q);
				mul_b = MUL_W'(b2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// product holds while the sequencer waits on the output register
	always_ff @(posedge clk) begin
		if (op != OP_NONE) begin
			prod_q <= DEC_W'(mul_p);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			dec_q    <= '0;
			r2_q     <= 1'b0;
			active_q <= 1'b0;
		end else begin
			unique case (op)
				OP_START_INIT: begin
					x_q  <= '0;
					y_q  <= COORD_BITS'(cfg.radius_y);
					dx_q <= '0;
					r2_q <= 1'b0;
				end
				OP_START_DEC: begin
					dec_q <= b2e - prod_q + (a2e >> 2);
				end
				OP_START_FIN: begin
					dy_q     <= {prod_q[SLOPE_W-2:0], 1'b0};
					active_q <= (y_q != '0);
				end
				OP_STEP: begin
					x_q      <= x_n;
					y_q      <= y_n;
					dx_q     <= dx_n;
					dy_q     <= dy_n;
					dec_q    <= dec_step;
					active_q <= (y_n != '0);
				end
				OP_SW_M3: begin
					dec_q <= prod_q + (b2e >> 2);
				end
				OP_SW_M5: begin
					dec_q <= dec_q + prod_q;
				end
				OP_SW_FIN: begin
					dec_q <= dec_q - prod_q;
					r2_q  <= 1'b1;
				end
				default: begin
					r2_q <= r2_q;
				end
			endcase
		end
	end

	// output register
	assign emit = (op == OP_START_FIN) || (op == OP_STEP) || (op == OP_IDLE_EMIT);
	assign cx_w = SUM_W'(cfg.center_x);
	assign cy_w = SUM_W'(cfg.center_y);
	assign xw   = SUM_W'(x_n);
	assign yw   = SUM_W'(y_n);
	assign s_r  = cx_w + xw;
	assign s_l  = cx_w - xw;
	assign s_d  = cy_w + yw;
	assign s_u  = cy_w - yw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (op == OP_IDLE_EMIT) begin
				px_right    <= '0;
				px_left     <= '0;
				py_down     <= '0;
				py_up       <= '0;
				point_valid <= 1'b0;
				done_res    <= 1'b0;
			end else begin
				px_right    <= s_r[OUT_W-1:0];
				px_left     <= s_l[OUT_W-1:0];
				py_down     <= s_d[OUT_W-1:0];
				py_up       <= s_u[OUT_W-1:0];
				point_valid <= 1'b1;
				done_res    <= (y_n == '0);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.active     = active_q;
	assign stat.region_two = r2_q;
	assign stat.r1_go      = r1_go;
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

[design/midpoint_ellipse_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Integer midpoint ellipse walker reporting four mirrored points per item.
// ----------------------------------------------------------------------------
// Usage:
// Program centre and radii over APB (pready always high, writes take effect
// at the access phase) while the block is idle. Items arrive on in_valid /
// in_stall with start_req: 1 starts a walk at (0, radius_y), 0 advances one
// step. Every item yields exactly one result transfer on out_valid /
// out_stall; after the last point (done_res) advances return point_valid 0.
// One item is worked at a time by a sequencer over a single shared
// multiplier. An advance runs in the exec state, a start in the init,
// decision and finish states; a step into region two first runs M1 to M5
// and FIN, as its decision term needs five multiplies. The next item is
// taken on the cycle after its predecessor's result is registered.
// The result sits in an output register: a stall there does not hold off
// acceptance, but the following result waits until the register drains.
// Reset clears the config, walk and valid registers; no walk is in progress.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top
	import mer_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    start_req,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] px_right,
	output logic signed [OUT_W-1:0] px_left,
	output logic signed [OUT_W-1:0] py_down,
	output logic signed [OUT_W-1:0] py_up,
	output logic                    point_valid,
	output logic                    done_res
);

	mer_cfg_t  cfg;
	mer_stat_t stat;
	dp_op_t    op;

	mer_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.start_req (start_req),
		.in_stall  (in_stall),
		.stat      (stat),
		.op        (op)
	);

	mer_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.op          (op),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.px_right    (px_right),
		.px_left     (px_left),
		.py_down     (py_down),
		.py_up       (py_up),
		.point_valid (point_valid),
		.done_res    (done_res)
	);

endmodule
